@@ hdl/stq_pkg.sv @@
package stq_pkg;

    // Fixed field widths
    localparam int OP_BITS       = 2;
    localparam int DELAY_BITS    = 32;
    localparam int TAG_PORT_BITS = 16;
    localparam int ID_BITS       = 31;
    localparam int KIND_BITS     = 3;
    localparam int TIME_BITS     = 48;

    // Defaults for the top-level parameters
    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_TAG_BITS    = 16;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

    // Event codes
    localparam logic [KIND_BITS-1:0] EV_ADDED     = 3'd0;
    localparam logic [KIND_BITS-1:0] EV_REJECTED  = 3'd1;
    localparam logic [KIND_BITS-1:0] EV_EXPIRED   = 3'd2;
    localparam logic [KIND_BITS-1:0] EV_REMOVED   = 3'd3;
    localparam logic [KIND_BITS-1:0] EV_NOT_FOUND = 3'd4;

    // Last id handed out before the counter wraps to zero
    localparam logic [ID_BITS-1:0] ID_LIMIT = 31'h7ffffffe;
    // Id that is never assigned
    localparam logic [ID_BITS-1:0] ID_NEVER = 31'h7fffffff;

    // Sign bit of the time word, offsets deadlines relative to now
    localparam logic [TIME_BITS-1:0] TIME_SIGN = 48'h8000_0000_0000;

    // Result of the shared slot compare
    typedef struct packed {
        logic later;   // slot deadline lies strictly later than the reference
        logic id_hit;  // slot id equals the wanted id
    } t_cmp_res;

endpackage

@@ hdl/stq_entry_ram.sv @@
module stq_entry_ram #(
    parameter int DEPTH = stq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int WIDTH = stq_pkg::TIME_BITS + stq_pkg::ID_BITS + stq_pkg::DEFAULT_TAG_BITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/stq_slot_cmp.sv @@
module stq_slot_cmp (
    input  logic [stq_pkg::TIME_BITS-1:0] i_deadline,
    input  logic [stq_pkg::TIME_BITS-1:0] i_now,
    input  logic [stq_pkg::TIME_BITS-1:0] i_ref_rel,
    input  logic [stq_pkg::ID_BITS-1:0]   i_ident,
    input  logic [stq_pkg::ID_BITS-1:0]   i_want_id,
    output stq_pkg::t_cmp_res             o_res
);

    logic [stq_pkg::TIME_BITS-1:0] rel;

    // Offset the deadline from now so that the counter wrap keeps the order
    assign rel = (i_deadline - i_now) ^ stq_pkg::TIME_SIGN;

    assign o_res.later  = (rel > i_ref_rel);
    assign o_res.id_hit = (i_ident == i_want_id);

endmodule

@@ hdl/sorted_timer_queue_core.sv @@
// Sorted timer queue. Keeps up to QUEUE_DEPTH pending timers in deadline order
// in a single-port-write / single-port-read memory, plus a tick-driven 48-bit
// tick count. An add word stores deadline now + delay (equal deadlines expire
// in the order added) and answers with a fresh id; a zero delay or a full
// queue answers "add rejected" and uses no id. A remove word deletes the first
// timer with that id and answers with its tag, or answers "not found". A tick
// word advances time by one and retires at most one expired head, answering
// only when a timer expires. Operation code 3 is taken and ignored.
// Timing: one shared compare unit walks the memory one slot per cycle. An add
// walks every entry and then the free slot behind them; a remove or an expiring
// tick walks every entry; a tick whose head has not expired looks at the head
// only; a tick on an empty queue, a rejected add and a remove on an empty queue
// walk no slot. The block takes no new word while an item is in work; a
// finished result waits in the output register without blocking the next
// input word. No clearing pass is needed after reset.
module sorted_timer_queue_core #(
    parameter int QUEUE_DEPTH = stq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int TAG_BITS    = stq_pkg::DEFAULT_TAG_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [stq_pkg::OP_BITS-1:0]       i_operation,
    input  logic [stq_pkg::DELAY_BITS-1:0]    i_delay_ticks,
    input  logic [stq_pkg::TAG_PORT_BITS-1:0] i_callback_tag,
    input  logic [stq_pkg::ID_BITS-1:0]       i_timer_id,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [stq_pkg::KIND_BITS-1:0]     o_event_kind,
    output logic [stq_pkg::ID_BITS-1:0]       o_event_id,
    output logic [stq_pkg::TAG_PORT_BITS-1:0] o_event_tag
);

    localparam int CW  = $clog2(QUEUE_DEPTH + 1);  // count and walk index
    localparam int AW  = $clog2(QUEUE_DEPTH);      // memory address
    localparam int TB  = stq_pkg::TIME_BITS;
    localparam int IB  = stq_pkg::ID_BITS;
    localparam int EW  = TB + IB + TAG_BITS;       // one stored entry
    localparam int TPB = stq_pkg::TAG_PORT_BITS;
    localparam int KB  = stq_pkg::KIND_BITS;

    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    // Walk modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_EXPIRE = 2'd2;

    // control state
    logic [1:0]          r_state, n_state;
    logic [TB-1:0]       r_now, n_now;
    logic [IB-1:0]       r_next_id, n_next_id;
    logic [CW-1:0]       r_count, n_count;
    logic                r_out_valid, n_out_valid;

    // per-item work registers
    logic [1:0]          r_mode, n_mode;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_hit, n_hit;
    logic [EW-1:0]       r_carry, n_carry;
    logic [TB-1:0]       r_new_dl, n_new_dl;
    logic [TB-1:0]       r_ref_rel, n_ref_rel;
    logic [IB-1:0]       r_key_id, n_key_id;
    logic [TAG_BITS-1:0] r_new_tag, n_new_tag;
    logic [KB-1:0]       r_res_kind, n_res_kind;
    logic [IB-1:0]       r_res_id, n_res_id;
    logic [TAG_BITS-1:0] r_res_tag, n_res_tag;
    logic [KB-1:0]       r_out_kind, n_out_kind;
    logic [IB-1:0]       r_out_id, n_out_id;
    logic [TPB-1:0]      r_out_tag, n_out_tag;

    // memory port
    logic                ram_we;
    logic [AW-1:0]       ram_wr_addr;
    logic [EW-1:0]       ram_wr_data;
    logic [AW-1:0]       ram_rd_addr;
    logic [EW-1:0]       ram_rd_data;

    logic [TB-1:0]       rd_dl;
    logic [IB-1:0]       rd_ident;
    logic [TAG_BITS-1:0] rd_tag;
    stq_pkg::t_cmp_res   cmp_res;

    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       idx_dec;
    logic                out_free;
    logic                slot_hit;

    assign rd_dl    = ram_rd_data[EW-1 -: TB];
    assign rd_ident = ram_rd_data[TAG_BITS +: IB];
    assign rd_tag   = ram_rd_data[TAG_BITS-1:0];

    assign idx_inc  = r_idx + 1'b1;
    assign idx_dec  = r_idx - 1'b1;

    // Output register frees up when empty or when its word leaves this cycle
    assign out_free = !r_out_valid || !i_stall;

    // A slot hits: for expiry the head is due, for removal the id matches
    assign slot_hit = (r_mode == MODE_EXPIRE) ? !cmp_res.later : cmp_res.id_hit;

    stq_entry_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    stq_slot_cmp u_cmp (
        .i_deadline (rd_dl),
        .i_now      (r_now),
        .i_ref_rel  (r_ref_rel),
        .i_ident    (rd_ident),
        .i_want_id  (r_key_id),
        .o_res      (cmp_res)
    );

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_next_id   = r_next_id;
        n_count     = r_count;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_carry     = r_carry;
        n_new_dl    = r_new_dl;
        n_ref_rel   = r_ref_rel;
        n_key_id    = r_key_id;
        n_new_tag   = r_new_tag;
        n_res_kind  = r_res_kind;
        n_res_id    = r_res_id;
        n_res_tag   = r_res_tag;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_tag   = r_out_tag;
        n_out_valid = r_out_valid && i_stall;

        ram_we      = 1'b0;
        ram_wr_addr = r_idx[AW-1:0];
        ram_wr_data = r_carry;
        ram_rd_addr = '0;

        case (r_state)
            ST_IDLE: begin
                // Fetch slot 0 so the walk can start next cycle
                n_idx = '0;
                n_hit = 1'b0;
                if (i_valid) begin
                    case (i_operation)
                        stq_pkg::OP_TICK: begin
                            n_now     = r_now + 1'b1;
                            n_mode    = MODE_EXPIRE;
                            n_ref_rel = stq_pkg::TIME_SIGN;
                            if (r_count != '0) begin
                                n_state = ST_WALK;
                            end
                        end
                        stq_pkg::OP_ADD: begin
                            if (i_delay_ticks == '0 || r_count == FULL_COUNT) begin
                                n_res_kind = stq_pkg::EV_REJECTED;
                                n_res_id   = '0;
                                n_res_tag  = '0;
                                n_state    = ST_SEND;
                            end else begin
                                n_mode    = MODE_INSERT;
                                n_new_dl  = r_now + TB'(i_delay_ticks);
                                n_ref_rel = stq_pkg::TIME_SIGN | TB'(i_delay_ticks);
                                n_key_id  = r_next_id;
                                n_new_tag = TAG_BITS'(64'(i_callback_tag));
                                n_next_id = (r_next_id >= stq_pkg::ID_LIMIT) ?
                                            '0 : r_next_id + 1'b1;
                                n_state   = ST_WALK;
                            end
                        end
                        stq_pkg::OP_REMOVE: begin
                            n_mode   = MODE_REMOVE;
                            n_key_id = i_timer_id;
                            if (r_count == '0) begin
                                n_res_kind = stq_pkg::EV_NOT_FOUND;
                                n_res_id   = '0;
                                n_res_tag  = '0;
                                n_state    = ST_SEND;
                            end else begin
                                n_state = ST_WALK;
                            end
                        end
                        default: begin
                            // unused code: drop the word
                        end
                    endcase
                end
            end

            ST_WALK: begin
                // Slot r_idx is on the read port; fetch the next one
                ram_rd_addr = idx_inc[AW-1:0];
                n_idx       = idx_inc;
                if (r_mode == MODE_INSERT) begin
                    // Ripple entries one slot up behind the insertion point
                    ram_we      = 1'b1;
                    ram_wr_addr = r_idx[AW-1:0];
                    n_carry     = ram_rd_data;
                    if (!r_hit && (r_idx == r_count || cmp_res.later)) begin
                        ram_wr_data = {r_new_dl, r_key_id, r_new_tag};
                        n_hit       = 1'b1;
                    end else if (!r_hit) begin
                        ram_we = 1'b0;
                    end
                    if (r_idx == r_count) begin
                        n_count    = r_count + 1'b1;
                        n_res_kind = stq_pkg::EV_ADDED;
                        n_res_id   = r_key_id;
                        n_res_tag  = '0;
                        n_state    = ST_SEND;
                    end
                end else begin
                    // Delete: move every later entry one slot down
                    if (r_hit) begin
                        ram_we      = 1'b1;
                        ram_wr_addr = idx_dec[AW-1:0];
                        ram_wr_data = ram_rd_data;
                    end else if (slot_hit) begin
                        n_hit     = 1'b1;
                        n_res_id  = rd_ident;
                        n_res_tag = rd_tag;
                    end
                    if (r_mode == MODE_EXPIRE && !r_hit && !slot_hit) begin
                        // head not due yet: nothing to report
                        n_state = ST_IDLE;
                    end else if (idx_inc == r_count) begin
                        if (r_hit || slot_hit) begin
                            n_count    = r_count - 1'b1;
                            n_res_kind = (r_mode == MODE_EXPIRE) ?
                                         stq_pkg::EV_EXPIRED : stq_pkg::EV_REMOVED;
                        end else begin
                            n_res_kind = stq_pkg::EV_NOT_FOUND;
                            n_res_id   = '0;
                            n_res_tag  = '0;
                        end
                        n_state = ST_SEND;
                    end
                end
            end

            ST_SEND: begin
                // Hold the result until the output register has room
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_id    = r_res_id;
                    n_out_tag   = TPB'(64'(r_res_tag));
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_next_id   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_next_id   <= n_next_id;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_carry    <= n_carry;
        r_new_dl   <= n_new_dl;
        r_ref_rel  <= n_ref_rel;
        r_key_id   <= n_key_id;
        r_new_tag  <= n_new_tag;
        r_res_kind <= n_res_kind;
        r_res_id   <= n_res_id;
        r_res_tag  <= n_res_tag;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_tag  <= n_out_tag;
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_event_id   = r_out_id;
    assign o_event_tag  = r_out_tag;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count beyond queue depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + 1'b1 ||
                            r_count == $past(r_count) - 1'b1))
        else $error("entry count moved by more than one");

    a_now_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_now == $past(r_now) || r_now == $past(r_now) + 1'b1))
        else $error("tick count jumped");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != stq_pkg::ID_NEVER)
        else $error("next id reached the reserved value");

    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_idx <= r_count))
        else $error("walk index past the last entry");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int QDEPTH = stq_pkg::DEFAULT_QUEUE_DEPTH;
    localparam int TAG_W  = stq_pkg::TAG_PORT_BITS;
    localparam int ID_W   = stq_pkg::ID_BITS;
    // The block takes this code and ignores it
    localparam logic [stq_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

    localparam int LONG_HOLD        = 300;   // receiver hold-off during the fill-up burst
    localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES     = 40;    // longer than the longest item, plus margin
    localparam int RANDOM_PER_PHASE = 140;

    // One input word as the sender sees it. live_id asks the driver to pick the
    // id of a pending timer at the moment the word is presented.
    typedef struct {
        logic [stq_pkg::OP_BITS-1:0]       op;
        logic [stq_pkg::DELAY_BITS-1:0]    delay;
        logic [stq_pkg::TAG_PORT_BITS-1:0] tag;
        logic [stq_pkg::ID_BITS-1:0]       id;
        bit                                live_id;
    } t_timer_req;

    typedef struct packed {
        logic [stq_pkg::KIND_BITS-1:0]     kind;
        logic [stq_pkg::ID_BITS-1:0]       id;
        logic [stq_pkg::TAG_PORT_BITS-1:0] tag;
    } t_timer_event;

    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_valid        = 1'b0;
    logic                              o_stall;
    logic [stq_pkg::OP_BITS-1:0]       i_operation    = stq_pkg::OP_TICK;
    logic [stq_pkg::DELAY_BITS-1:0]    i_delay_ticks  = '0;
    logic [stq_pkg::TAG_PORT_BITS-1:0] i_callback_tag = '0;
    logic [stq_pkg::ID_BITS-1:0]       i_timer_id     = '0;
    logic                              o_valid;
    logic                              i_stall        = 1'b0;
    logic [stq_pkg::KIND_BITS-1:0]     o_event_kind;
    logic [stq_pkg::ID_BITS-1:0]       o_event_id;
    logic [stq_pkg::TAG_PORT_BITS-1:0] o_event_tag;

    sorted_timer_queue_core #(
        .QUEUE_DEPTH (QDEPTH),
        .TAG_BITS    (stq_pkg::DEFAULT_TAG_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_delay_ticks  (i_delay_ticks),
        .i_callback_tag (i_callback_tag),
        .i_timer_id     (i_timer_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_event_id     (o_event_id),
        .o_event_tag    (o_event_tag)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Timer queue predictor: own copy of the tick count, id counter and the
    // deadline-sorted entries, updated once per accepted word.
    // ------------------------------------------------------------------
    logic [stq_pkg::TIME_BITS-1:0]     model_now;
    logic [stq_pkg::ID_BITS-1:0]       model_next_id;
    int                                model_count;
    logic [stq_pkg::TIME_BITS-1:0]     model_deadline [QDEPTH];
    logic [stq_pkg::ID_BITS-1:0]       model_ident    [QDEPTH];
    logic [stq_pkg::TAG_PORT_BITS-1:0] model_tag      [QDEPTH];

    t_timer_event events_due[$];   // events the block still owes us, oldest first
    t_timer_req   req_pending[$];  // words waiting to be offered
    t_timer_req   in_flight;       // word currently on the input port

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int words_taken    = 0;
    int events_seen    = 0;
    int n_fail         = 0;
    int kind_count[5]  = '{default: 0};

    // Compare deadlines as offsets from now so that the counter wrap keeps order
    function automatic bit deadline_after(logic [stq_pkg::TIME_BITS-1:0] a,
                                          logic [stq_pkg::TIME_BITS-1:0] b);
        logic [stq_pkg::TIME_BITS-1:0] ra;
        logic [stq_pkg::TIME_BITS-1:0] rb;
        ra = a - model_now + stq_pkg::TIME_SIGN;
        rb = b - model_now + stq_pkg::TIME_SIGN;
        return ra > rb;
    endfunction

    function automatic t_timer_event make_event(logic [stq_pkg::KIND_BITS-1:0] kind,
                                                logic [stq_pkg::ID_BITS-1:0] id,
                                                logic [stq_pkg::TAG_PORT_BITS-1:0] tag);
        t_timer_event ev;
        ev.kind = kind;
        ev.id   = id;
        ev.tag  = tag;
        return ev;
    endfunction

    // Close the gap left by slot k
    task automatic drop_entry(int k);
        for (int i = k; i + 1 < model_count; i++) begin
            model_deadline[i] = model_deadline[i + 1];
            model_ident[i]    = model_ident[i + 1];
            model_tag[i]      = model_tag[i + 1];
        end
        model_count--;
    endtask

    task automatic advance_timer_queue(t_timer_req w);
        logic [stq_pkg::TIME_BITS-1:0] due;
        int pos;
        int hit;
        case (w.op)
            stq_pkg::OP_TICK: begin
                // Advance time first, then retire at most one expired head
                model_now = model_now + 1'b1;
                if (model_count > 0 && !deadline_after(model_deadline[0], model_now)) begin
                    events_due.push_back(make_event(stq_pkg::EV_EXPIRED,
                                                    model_ident[0], model_tag[0]));
                    drop_entry(0);
                end
            end
            stq_pkg::OP_ADD: begin
                if (w.delay == '0 || model_count >= QDEPTH) begin
                    events_due.push_back(make_event(stq_pkg::EV_REJECTED, '0, '0));
                end else begin
                    due = model_now + w.delay;
                    // Insert behind every entry due at or before the new deadline
                    pos = model_count;
                    for (int i = 0; i < model_count; i++)
                        if (pos == model_count && deadline_after(model_deadline[i], due))
                            pos = i;
                    for (int i = model_count; i > pos; i--) begin
                        model_deadline[i] = model_deadline[i - 1];
                        model_ident[i]    = model_ident[i - 1];
                        model_tag[i]      = model_tag[i - 1];
                    end
                    model_deadline[pos] = due;
                    model_ident[pos]    = model_next_id;
                    model_tag[pos]      = w.tag;
                    model_count++;
                    events_due.push_back(make_event(stq_pkg::EV_ADDED, model_next_id, '0));
                    model_next_id = (model_next_id >= stq_pkg::ID_LIMIT) ?
                                    '0 : model_next_id + 1'b1;
                end
            end
            stq_pkg::OP_REMOVE: begin
                hit = -1;
                for (int i = 0; i < model_count; i++)
                    if (hit < 0 && model_ident[i] == w.id)
                        hit = i;
                if (hit >= 0) begin
                    events_due.push_back(make_event(stq_pkg::EV_REMOVED, w.id,
                                                    model_tag[hit]));
                    drop_entry(hit);
                end else begin
                    events_due.push_back(make_event(stq_pkg::EV_NOT_FOUND, '0, '0));
                end
            end
            default: ;  // unused code: no event, no state change
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(logic [stq_pkg::OP_BITS-1:0] op,
                             logic [stq_pkg::DELAY_BITS-1:0] delay,
                             logic [stq_pkg::TAG_PORT_BITS-1:0] tag,
                             logic [stq_pkg::ID_BITS-1:0] id,
                             bit live_id = 1'b0);
        t_timer_req w;
        w.op      = op;
        w.delay   = delay;
        w.tag     = tag;
        w.id      = id;
        w.live_id = live_id;
        req_pending.push_back(w);
    endtask

    // Mostly ticks and short adds so that timers really expire; some long and
    // full-range delays, zero delays, removes of live and stale ids, noise.
    function automatic t_timer_req random_word();
        t_timer_req w;
        int pick;
        w.op      = stq_pkg::OP_TICK;
        w.delay   = $urandom;
        w.tag     = TAG_W'($urandom);
        w.id      = ID_W'($urandom);
        w.live_id = 1'b0;
        pick = $urandom_range(99);
        if (pick < 45) begin
            w.op = stq_pkg::OP_TICK;
        end else if (pick < 75) begin
            w.op = stq_pkg::OP_ADD;
            pick = $urandom_range(99);
            if (pick < 6)
                w.delay = '0;
            else if (pick < 70)
                w.delay = $urandom_range(30, 1);
            else if (pick < 88)
                w.delay = $urandom_range(400, 1);
        end else if (pick < 97) begin
            w.op = stq_pkg::OP_REMOVE;
            pick = $urandom_range(99);
            if (pick < 70)
                w.live_id = 1'b1;
            else if (pick < 85)
                w.id = ID_W'($urandom_range(700));  // likely an id that already left
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    // Hold the sender until every word went in and every owed event came out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_pending.size() != 0 || i_valid || events_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next pending word, hold it while stalled, run the
    // predictor on every accepted word.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_timer_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                advance_timer_queue(in_flight);
                words_taken++;
            end
            // A stalled word stays on the port untouched
            if (!(i_valid && o_stall)) begin
                if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = req_pending.pop_front();
                    // Pick the id now, against the state the block will see
                    if (nxt.live_id && model_count > 0)
                        nxt.id = model_ident[$urandom_range(model_count - 1)];
                    in_flight = nxt;
                    i_valid        <= 1'b1;
                    i_operation    <= nxt.op;
                    i_delay_ticks  <= nxt.delay;
                    i_callback_tag <= nxt.tag;
                    i_timer_id     <= nxt.id;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted event against the oldest owed one and
    // drive the receiver stall (random, or a long hold-off on request).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_timer_event want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                events_seen++;
                if (events_due.size() == 0) begin
                    $error("unexpected event: kind %0d id 0x%0h tag 0x%0h",
                           o_event_kind, o_event_id, o_event_tag);
                    n_fail++;
                end else begin
                    want = events_due.pop_front();
                    kind_count[want.kind]++;
                    if (o_event_kind !== want.kind) begin
                        $error("event_kind mismatch: expected %0d, got %0d",
                               want.kind, o_event_kind);
                        n_fail++;
                    end
                    if (o_event_id !== want.id) begin
                        $error("event_id mismatch: expected 0x%0h, got 0x%0h",
                               want.id, o_event_id);
                        n_fail++;
                    end
                    if (o_event_tag !== want.tag) begin
                        $error("event_tag mismatch: expected 0x%0h, got 0x%0h",
                               want.tag, o_event_tag);
                        n_fail++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else if (holds_served != hold_requests) begin
                holds_served <= holds_served + 1;
                hold_left    <= LONG_HOLD;
                i_stall      <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_timer_queue_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed words, fill-up burst under a long hold-off,
    // then random phases with different idle patterns.
    // ------------------------------------------------------------------
    initial begin
        model_now     = '0;
        model_next_id = '0;
        model_count   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_word(stq_pkg::OP_TICK,   '0,            '0,       '0);  // tick on empty queue
        push_word(stq_pkg::OP_REMOVE, '0,            '0,       '0);  // remove on empty queue
        push_word(stq_pkg::OP_ADD,    '0,            16'hffff, '0);  // zero delay, rejected
        push_word(stq_pkg::OP_ADD,    32'd1,         16'hffff, '0);  // id 0
        push_word(stq_pkg::OP_ADD,    32'd1,         16'h0000, '0);  // id 1, equal deadline
        push_word(stq_pkg::OP_ADD,    32'hffff_ffff, 16'h5a5a, '0);  // id 2, farthest out
        push_word(OP_UNUSED,          '1,            '1,       '1);  // ignored code
        push_word(stq_pkg::OP_REMOVE, '0, '0, stq_pkg::ID_NEVER);    // id that never matches
        push_word(stq_pkg::OP_ADD,    32'd8,         16'h1111, '0);  // id 3
        push_word(stq_pkg::OP_ADD,    32'd6,         16'h2222, '0);  // id 4
        push_word(stq_pkg::OP_ADD,    32'd6,         16'h3333, '0);  // id 5, behind id 4
        push_word(stq_pkg::OP_ADD,    32'd2,         16'h4444, '0);  // id 6, near the head
        push_word(stq_pkg::OP_REMOVE, '0,            '0,    31'd4);  // drop from the middle
        repeat (4) push_word(stq_pkg::OP_TICK, '0, '0, '0);          // expire ids 0, 1, 6
        push_word(stq_pkg::OP_REMOVE, '0,            '0,    31'd2);
        push_word(stq_pkg::OP_REMOVE, '0,            '0,    31'd3);
        push_word(stq_pkg::OP_REMOVE, '0,            '0,    31'd5);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            if (ph == 0) begin
                // Hold the receiver off while long adds keep coming: the block
                // backs up, the queue fills and the last adds are rejected.
                hold_requests++;
                repeat (20) push_word(stq_pkg::OP_ADD,
                                      $urandom_range(32'hffff_ffff, 32'h1000_0000),
                                      TAG_W'($urandom), '0);
                repeat (20) push_word(stq_pkg::OP_REMOVE, '0, '0, '0, 1'b1);
            end
            repeat (RANDOM_PER_PHASE) req_pending.push_back(random_word());
            wait_drained();
        end

        // Catch any stray event after the last owed one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (events_due.size() != 0) begin
            $error("%0d expected events never arrived", events_due.size());
            n_fail++;
        end
        $display("covered %0d words in, %0d events out: %0d added, %0d rejected,",
                 words_taken, events_seen, kind_count[stq_pkg::EV_ADDED],
                 kind_count[stq_pkg::EV_REJECTED]);
        $display("  %0d expired, %0d removed, %0d not found, with idle, stall and hold-off",
                 kind_count[stq_pkg::EV_EXPIRED], kind_count[stq_pkg::EV_REMOVED],
                 kind_count[stq_pkg::EV_NOT_FOUND]);
        if (n_fail == 0)
            $display("sorted_timer_queue_core regression: pass");
        else
            $display("sorted_timer_queue_core regression: fail");
        $finish;
    end

endmodule
